// ===== hw/rtl/vbs_pkg.sv =====
// Package of shared codes, widths and constants for the video background subtractor.
package vbs_pkg;

    // field widths fixed by the stream formats
    localparam int ACTION_W   = 2;
    localparam int INDEX_W    = 17;
    localparam int PIXEL_W    = 24;
    localparam int LUMA_W     = 11;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 24;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [INDEX_W-1:0]  t_index;
    typedef logic [PIXEL_W-1:0]  t_pixel;
    typedef logic [LUMA_W-1:0]   t_luma;

    // request actions
    localparam t_action ACT_LOAD    = 2'd0;
    localparam t_action ACT_COMPARE = 2'd1;
    localparam t_action ACT_REPLACE = 2'd2;
    localparam t_action ACT_UNUSED  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_COLOR_MODE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LUMA_THR   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RGB_MASK   = 2'd2;

    // per-channel RGB compare constants
    localparam logic [31:0] RGB_BORROW_BITS = 32'h0101_0100;
    localparam logic [31:0] RGB_CLEAR_LSB   = 32'h00fe_fefe;
    localparam logic [31:0] RGB_ALL_ONES    = 32'h00ff_ffff;

endpackage

// ===== hw/rtl/video_background_subtractor_unit.sv =====
// Video background subtractor: per-pixel background store with luma or RGB compare.
//
// Channels: requests arrive on the slave stream (i_s_tvalid / o_s_tready), each with an
// action in tuser and a pixel index and pixel colour in tdata. A load writes the pixel
// into the background store and gives no result. A compare, or a compare-then-replace,
// gives one result on the master stream: the index echoed and a foreground flag.
// Action code three is dropped without a result.
// Configuration (colour mode, luma threshold, RGB mask) is written on the plain write
// port. The user must write it only while the block is idle; this is not enforced.
// Throughput: one request per cycle unless stalled, set by the single-port background
// memory, read and written at the request's address in the same cycle (read-first),
// so a following request at the same index sees the new pixel without forwarding.
// Result path: an accepted request's memory read and payload enter the compare stage;
// its compare result is registered into the output register when that register is
// empty or being taken, and is presented on the master stream from there.
// Reset clears the pipeline valids and the configuration registers; the store is not
// cleared and an entry reads undefined until a load or replace has written it.
// When the receiver stalls the output register and the compare stage hold; o_s_tready
// drops only while both are full and i_m_tready is low.
module video_background_subtractor_unit #(
    parameter int FRAME_PIXELS = 131072
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [vbs_pkg::S_TDATA_W-1:0]     i_s_tdata,  // pixel_index[16:0], pixel[40:17]
    input  logic [vbs_pkg::ACTION_W-1:0]      i_s_tuser,  // action[1:0]
    // master stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [vbs_pkg::M_TDATA_W-1:0]     o_m_tdata,  // result_index[16:0], foreground[17]
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [vbs_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [vbs_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import vbs_pkg::*;

    localparam int ADDR_W  = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int EXT_W   = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

    // configuration registers
    logic        r_color_mode;
    t_luma       r_luma_thr;
    t_pixel      r_rgb_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= 1'b0;
            r_luma_thr   <= '0;
            r_rgb_mask   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_COLOR_MODE: r_color_mode <= i_cfg_wdata[0];
                CFG_LUMA_THR:   r_luma_thr   <= i_cfg_wdata[LUMA_W-1:0];
                CFG_RGB_MASK:   r_rgb_mask   <= i_cfg_wdata[PIXEL_W-1:0];
                default: ;
            endcase
        end
    end

    // request decode
    t_action              in_action;
    t_index               in_index;
    t_pixel               in_pixel;
    logic [EXT_W-1:0]     in_index_ext;
    logic [ADDR_W-1:0]    in_addr;
    logic                 in_inside;
    logic                 in_accept;
    logic                 in_has_result;
    logic                 in_write;

    assign in_action     = i_s_tuser;
    assign in_index      = i_s_tdata[INDEX_W-1:0];
    assign in_pixel      = i_s_tdata[INDEX_W+PIXEL_W-1:INDEX_W];
    assign in_index_ext  = EXT_W'(in_index);
    assign in_addr       = in_index_ext[ADDR_W-1:0];
    assign in_inside     = in_index_ext < EXT_W'(FRAME_PIXELS);
    assign in_accept     = i_s_tvalid && o_s_tready;
    assign in_has_result = (in_action == ACT_COMPARE) || (in_action == ACT_REPLACE);
    assign in_write      = in_inside && ((in_action == ACT_LOAD) || (in_action == ACT_REPLACE));

    // pipeline registers
    logic        r_s1_valid;
    t_index      r_s1_index;
    t_pixel      r_s1_pixel;
    logic        r_s1_inside;
    t_pixel      r_rd_data;
    logic        r_out_valid;
    t_index      r_out_index;
    logic        r_out_fg;

    logic        s1_advance;

    assign s1_advance = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || s1_advance;

    // background store: read-first, read and write at the request address
    t_pixel mem [FRAME_PIXELS];

    always_ff @(posedge i_clk) begin
        if (in_accept && in_write) begin
            mem[in_addr] <= in_pixel;
        end
        if (in_accept) begin
            r_rd_data <= mem[in_addr];
        end
    end

    // compare stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= in_has_result;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    // hold the request payload beside the memory read
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_index  <= in_index;
            r_s1_pixel  <= in_pixel;
            r_s1_inside <= in_inside;
        end
    end

    // compare against the background
    t_pixel      bg;
    t_luma       luma_new;
    t_luma       luma_bg;
    t_luma       luma_diff;
    logic [31:0] rgb_a;
    logic [31:0] rgb_g;
    logic [31:0] rgb_x;
    logic        luma_fg;
    logic        rgb_fg;
    logic        s1_fg;

    assign bg       = r_s1_inside ? r_rd_data : '0;
    assign luma_new = LUMA_W'({r_s1_pixel[23:16], 1'b0}) + LUMA_W'({r_s1_pixel[15:8], 2'b00})
                    + LUMA_W'(r_s1_pixel[7:0]);
    assign luma_bg  = LUMA_W'({bg[23:16], 1'b0}) + LUMA_W'({bg[15:8], 2'b00})
                    + LUMA_W'(bg[7:0]);
    assign luma_diff = (luma_new >= luma_bg) ? (luma_new - luma_bg) : (luma_bg - luma_new);
    assign luma_fg   = luma_diff > r_luma_thr;

    assign rgb_a  = (32'(r_s1_pixel) | RGB_BORROW_BITS) - (32'(bg) & RGB_CLEAR_LSB);
    assign rgb_g  = rgb_a & RGB_BORROW_BITS;
    assign rgb_x  = rgb_a ^ ((rgb_g - (rgb_g >> 8)) ^ RGB_ALL_ONES);
    assign rgb_fg = |(rgb_x[PIXEL_W-1:0] & r_rgb_mask);

    assign s1_fg  = r_color_mode ? rgb_fg : luma_fg;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_valid) begin
            r_out_index <= r_s1_index;
            r_out_fg    <= s1_fg;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W-INDEX_W-1){1'b0}}, r_out_fg, r_out_index};

    // checks
    a_ready_low_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_s1_valid && r_out_valid && !i_m_tready))
        else $error("input stalled while the pipeline has room");

    a_no_result_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !in_has_result) |=> !r_s1_valid)
        else $error("load or unused action entered the compare stage");

    a_result_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && in_has_result) |=> (r_s1_valid && r_s1_index == $past(in_index)))
        else $error("compare request lost on entry");

    a_out_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("result appeared without a compare in flight");

endmodule

// ===== tb/sv/tb_video_background_subtractor_unit.sv =====
// Testbench for the video background subtractor: directed and random requests checked against a predictor.
module tb_video_background_subtractor_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import vbs_pkg::*;

    localparam int FRAME_PIXELS = 131072;
    localparam int PIPE_LATENCY = 2;
    localparam int RANDOM_PER_PHASE = 130;

    typedef struct packed {
        t_index index;
        logic   foreground;
    } t_verdict;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata = '0;   // pixel_index[16:0], pixel[40:17]
    logic [ACTION_W-1:0]   i_s_tuser = '0;   // action[1:0]
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;        // result_index[16:0], foreground[17]
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // shadow of the block's configuration and background store
    bit       cfg_color_mode;
    t_luma    cfg_luma_thr;
    t_pixel   cfg_rgb_mask;
    t_pixel   background [t_index];
    t_index   loaded_positions [$];

    t_verdict expected_verdicts [$];
    int       send_idle_pct;
    int       ready_idle_pct;
    int       mismatch_count;
    int       request_count;
    int       verdict_count;
    int       foreground_count;

    video_background_subtractor_unit #(
        .FRAME_PIXELS(FRAME_PIXELS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= ready_idle_pct);
    end

    // Decide foreground from the new pixel and the stored background
    function automatic bit is_foreground(t_pixel px, t_pixel bg);
        int          luma_new;
        int          luma_bg;
        int          luma_diff;
        logic [31:0] acc;
        logic [31:0] borrow;
        if (!cfg_color_mode) begin
            luma_new  = 2 * px[23:16] + 4 * px[15:8] + px[7:0];
            luma_bg   = 2 * bg[23:16] + 4 * bg[15:8] + bg[7:0];
            luma_diff = luma_new - luma_bg;
            return (luma_diff > int'(cfg_luma_thr)) || (luma_diff < -int'(cfg_luma_thr));
        end
        // per-channel difference: borrow bits keep channels apart
        acc    = ({8'h00, px} | RGB_BORROW_BITS) - ({8'h00, bg} & RGB_CLEAR_LSB);
        borrow = acc & RGB_BORROW_BITS;
        acc    = acc ^ ((borrow - (borrow >> 8)) ^ RGB_ALL_ONES);
        return |(acc[23:0] & cfg_rgb_mask);
    endfunction

    // Store a pixel as background, noting first writes
    function automatic void store_background(t_index idx, t_pixel px);
        if (int'(idx) >= FRAME_PIXELS)
            return;
        if (!background.exists(idx))
            loaded_positions.push_back(idx);
        background[idx] = px;
    endfunction

    // Advance the shadow state for one accepted request
    function automatic void predict_request(t_action act, t_index idx, t_pixel px);
        t_pixel   bg;
        t_verdict verdict;
        request_count++;
        case (act) inside
            ACT_LOAD: begin
                store_background(idx, px);
            end
            ACT_COMPARE, ACT_REPLACE: begin
                bg = (int'(idx) < FRAME_PIXELS && background.exists(idx)) ? background[idx] : '0;
                verdict.index      = idx;
                verdict.foreground = is_foreground(px, bg);
                expected_verdicts.push_back(verdict);
                if (act == ACT_REPLACE)
                    store_background(idx, px);
            end
            default: begin
            end
        endcase
    endfunction

    // Send one request; called and returning just after a falling edge
    task automatic send_request(t_action act, t_index idx, t_pixel px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = act;
        i_s_tdata  = S_TDATA_W'({px, idx});
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        predict_request(act, idx, px);
        @(negedge i_clk);
    endtask

    // Hold off requests until every verdict is back and the pipeline is empty
    task automatic drain_results();
        i_s_tvalid = 1'b0;
        while (expected_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_LATENCY + 2) @(negedge i_clk);
    endtask

    // Write one configuration register; block must be idle
    task automatic write_config(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_wdata = data;
        case (addr)
            CFG_COLOR_MODE: cfg_color_mode = data[0];
            CFG_LUMA_THR:   cfg_luma_thr   = data[LUMA_W-1:0];
            CFG_RGB_MASK:   cfg_rgb_mask   = data[PIXEL_W-1:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Check each delivered verdict against the oldest expectation
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t unexpected verdict: expected none, got index %0d fg %0b",
                         $time, o_m_tdata[16:0], o_m_tdata[17]);
                mismatch_count++;
            end else begin
                want = expected_verdicts.pop_front();
                verdict_count++;
                if (want.foreground)
                    foreground_count++;
                if (o_m_tdata[16:0] !== want.index) begin
                    $display("%0t result_index mismatch: expected %0d, got %0d",
                             $time, want.index, o_m_tdata[16:0]);
                    mismatch_count++;
                end
                if (o_m_tdata[17] !== want.foreground) begin
                    $display("%0t foreground mismatch at index %0d: expected %0b, got %0b",
                             $time, want.index, want.foreground, o_m_tdata[17]);
                    mismatch_count++;
                end
            end
        end
    end

    // Luma mode at both threshold extremes, store extremes of index and pixel
    task automatic test_luma_compare();
        write_config(CFG_COLOR_MODE, '0);
        write_config(CFG_LUMA_THR, '0);
        write_config(CFG_RGB_MASK, '0);
        send_request(ACT_LOAD, 17'd0, 24'h000000);
        send_request(ACT_LOAD, 17'd131071, 24'hffffff);
        send_request(ACT_LOAD, 17'h0aaaa, 24'h808080);
        send_request(ACT_COMPARE, 17'd0, 24'h000000);
        send_request(ACT_COMPARE, 17'd0, 24'h000001);
        send_request(ACT_COMPARE, 17'd131071, 24'hffffff);
        send_request(ACT_COMPARE, 17'h0aaaa, 24'h7f8080);
        drain_results();
        write_config(CFG_LUMA_THR, 24'd1785);
        send_request(ACT_COMPARE, 17'd0, 24'hffffff);
        send_request(ACT_COMPARE, 17'd131071, 24'h000000);
        send_request(ACT_COMPARE, 17'h0aaaa, 24'h000000);
        drain_results();
    endtask

    // RGB mode with empty, full and per-channel masks
    task automatic test_rgb_compare();
        write_config(CFG_COLOR_MODE, 24'd1);
        write_config(CFG_RGB_MASK, 24'hffffff);
        send_request(ACT_COMPARE, 17'd0, 24'h000000);
        send_request(ACT_COMPARE, 17'd0, 24'h010101);
        send_request(ACT_COMPARE, 17'd131071, 24'h000000);
        drain_results();
        write_config(CFG_RGB_MASK, 24'hc0f8fe);
        send_request(ACT_COMPARE, 17'h0aaaa, 24'h818181);
        send_request(ACT_COMPARE, 17'h0aaaa, 24'h40ff00);
        drain_results();
        write_config(CFG_RGB_MASK, '0);
        send_request(ACT_COMPARE, 17'd131071, 24'h000000);
        drain_results();
    endtask

    // Replace followed at once by a compare at the same index; unused action is dropped
    task automatic test_replace_and_unused();
        write_config(CFG_COLOR_MODE, '0);
        write_config(CFG_LUMA_THR, '0);
        send_request(ACT_REPLACE, 17'd131071, 24'h000000);
        send_request(ACT_COMPARE, 17'd131071, 24'h000000);
        send_request(ACT_UNUSED, 17'h15555, 24'h555555);
        send_request(ACT_REPLACE, 17'h0aaaa, 24'hff00ff);
        send_request(ACT_COMPARE, 17'h0aaaa, 24'hff00ff);
        drain_results();
    endtask

    // Pick a random threshold mask, mostly one shift per channel
    function automatic t_pixel random_rgb_mask();
        t_pixel mask;
        if ($urandom_range(3) == 0)
            return t_pixel'($urandom);
        for (int ch = 0; ch < 3; ch++)
            mask[ch*8 +: 8] = 8'hff << $urandom_range(8);
        return mask;
    endfunction

    // Random traffic: mostly compares on loaded positions, with loads and noise
    task automatic test_random_stream(int send_pct, int ready_pct);
        t_index idx;
        t_pixel px;
        int     roll;
        int     counted;
        send_idle_pct  = send_pct;
        ready_idle_pct = ready_pct;
        write_config(CFG_COLOR_MODE, 24'($urandom_range(1)));
        write_config(CFG_LUMA_THR, 24'($urandom_range(1785)));
        write_config(CFG_RGB_MASK, random_rgb_mask());
        counted = 0;
        while (counted < RANDOM_PER_PHASE) begin
            // midway: let the block drain completely, then swap mode and thresholds
            if (counted == RANDOM_PER_PHASE / 2) begin
                drain_results();
                write_config(CFG_COLOR_MODE, 24'(!cfg_color_mode));
                write_config(CFG_LUMA_THR, 24'($urandom_range(1785)));
                write_config(CFG_RGB_MASK, random_rgb_mask());
            end
            roll = $urandom_range(99);
            px   = t_pixel'($urandom);
            if (roll < 20 || loaded_positions.size() == 0) begin
                send_request(ACT_LOAD, t_index'($urandom_range(131071)), px);
                counted++;
            end else if (roll < 92) begin
                idx = loaded_positions[$urandom_range(loaded_positions.size() - 1)];
                // half the compares sit close to the background
                if ($urandom_range(1))
                    px = background[idx] ^ (t_pixel'($urandom) & 24'h0f0f0f);
                if (roll < 85)
                    send_request($urandom_range(1) ? ACT_COMPARE : ACT_REPLACE, idx, px);
                else
                    send_request(ACT_LOAD, idx, px);
                counted++;
            end else begin
                send_request(ACT_UNUSED, t_index'($urandom_range(131071)), px);
            end
        end
        drain_results();
    endtask

    initial begin
        mismatch_count   = 0;
        request_count    = 0;
        verdict_count    = 0;
        foreground_count = 0;
        send_idle_pct    = 0;
        ready_idle_pct   = 0;
        cfg_color_mode   = 1'b0;
        cfg_luma_thr     = '0;
        cfg_rgb_mask     = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_luma_compare();
        test_rgb_compare();
        test_replace_and_unused();
        test_random_stream(13, 77);
        test_random_stream(77, 13);
        test_random_stream(0, 0);
        drain_results();

        $display("%0d requests sent, %0d verdicts checked, %0d of them foreground",
                 request_count, verdict_count, foreground_count);
        $display("luma and RGB modes, threshold extremes, replace hazards and dropped actions");
        if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("timeout with %0d verdicts outstanding", expected_verdicts.size());
        $display("simulation failed");
        $finish;
    end

endmodule
